// ===== hdl/c8alu_pkg.sv =====
// ----------------------------------------------------------------------------
// c8alu_pkg
// Shared operation codes and the records that pass between the ALU stages.
// ----------------------------------------------------------------------------
package c8alu_pkg;

  localparam int unsigned OpWidth   = 5;
  localparam int unsigned DataWidth = 8;

  typedef enum logic [OpWidth-1:0] {
    OP_ADD = 5'd0,
    OP_ADC = 5'd1,
    OP_SUB = 5'd2,
    OP_SBB = 5'd3,
    OP_ANA = 5'd4,
    OP_XRA = 5'd5,
    OP_ORA = 5'd6,
    OP_CMP = 5'd7,
    OP_INR = 5'd8,
    OP_DCR = 5'd9,
    OP_RLC = 5'd10,
    OP_RRC = 5'd11,
    OP_RAL = 5'd12,
    OP_RAR = 5'd13,
    OP_CMA = 5'd14,
    OP_STC = 5'd15,
    OP_CMC = 5'd16
  } alu_op_t;

  typedef struct packed {
    logic [OpWidth-1:0]   op;
    logic [DataWidth-1:0] a;
    logic [DataWidth-1:0] b;
    logic                 cy;
    logic                 s;
    logic                 z;
    logic                 p;
    logic                 ac;
  } alu_req_t;

  typedef struct packed {
    logic [DataWidth-1:0] res;
    logic                 wr;
    logic                 szp;
    logic                 cy;
    logic                 ac;
    logic                 s;
    logic                 z;
    logic                 p;
  } alu_exe_t;

endpackage

// ===== hdl/c8alu_exec.sv =====
// ----------------------------------------------------------------------------
// c8alu_exec
// Computes the result byte, carry, auxiliary carry and write mark of one item.
// ----------------------------------------------------------------------------
module c8alu_exec
  import c8alu_pkg::*;
(
  input  alu_req_t req,
  output alu_exe_t exe
);

  logic                 is_sub;
  logic                 cin;
  logic [DataWidth-1:0] bx;
  logic [DataWidth:0]   sum;
  logic [4:0]           nib;

  always_comb begin
    is_sub = (req.op == OP_SUB) || (req.op == OP_SBB) || (req.op == OP_CMP);
    bx     = is_sub ? ~req.b : req.b;
    if (req.op == OP_ADC) begin
      cin = req.cy;
    end else if (req.op == OP_SBB) begin
      cin = ~req.cy;
    end else begin
      cin = is_sub;
    end
    sum = {1'b0, req.a} + {1'b0, bx} + {{DataWidth{1'b0}}, cin};
    nib = {1'b0, req.a[3:0]} + {1'b0, bx[3:0]} + {4'd0, cin};
  end

  always_comb begin
    exe.res = req.a;
    exe.wr  = 1'b0;
    exe.szp = 1'b0;
    exe.cy  = req.cy;
    exe.ac  = req.ac;
    exe.s   = req.s;
    exe.z   = req.z;
    exe.p   = req.p;
    unique case (req.op)
      OP_ADD, OP_ADC, OP_SUB, OP_SBB, OP_CMP: begin
        exe.res = sum[DataWidth-1:0];
        exe.cy  = sum[DataWidth] ^ is_sub;
        exe.ac  = nib[4];
        exe.wr  = (req.op != OP_CMP);
        exe.szp = 1'b1;
      end
      OP_ANA: begin
        exe.res = req.a & req.b;
        exe.cy  = 1'b0;
        exe.ac  = req.a[3] | req.b[3];
        exe.wr  = 1'b1;
        exe.szp = 1'b1;
      end
      OP_XRA: begin
        exe.res = req.a ^ req.b;
        exe.cy  = 1'b0;
        exe.ac  = 1'b0;
        exe.wr  = 1'b1;
        exe.szp = 1'b1;
      end
      OP_ORA: begin
        exe.res = req.a | req.b;
        exe.cy  = 1'b0;
        exe.ac  = 1'b0;
        exe.wr  = 1'b1;
        exe.szp = 1'b1;
      end
      OP_INR: begin
        exe.res = req.a + 8'd1;
        exe.ac  = (req.a[3:0] == 4'hF);
        exe.wr  = 1'b1;
        exe.szp = 1'b1;
      end
      OP_DCR: begin
        exe.res = req.a - 8'd1;
        exe.ac  = (req.a[3:0] != 4'h0);
        exe.wr  = 1'b1;
        exe.szp = 1'b1;
      end
      OP_RLC: begin
        exe.res = {req.a[6:0], req.a[7]};
        exe.cy  = req.a[7];
        exe.wr  = 1'b1;
      end
      OP_RRC: begin
        exe.res = {req.a[0], req.a[7:1]};
        exe.cy  = req.a[0];
        exe.wr  = 1'b1;
      end
      OP_RAL: begin
        exe.res = {req.a[6:0], req.cy};
        exe.cy  = req.a[7];
        exe.wr  = 1'b1;
      end
      OP_RAR: begin
        exe.res = {req.cy, req.a[7:1]};
        exe.cy  = req.a[0];
        exe.wr  = 1'b1;
      end
      OP_CMA: begin
        exe.res = ~req.a;
        exe.wr  = 1'b1;
      end
      OP_STC: begin
        exe.cy = 1'b1;
      end
      OP_CMC: begin
        exe.cy = ~req.cy;
      end
      default: begin
        exe.res = req.a;
      end
    endcase
  end

endmodule

// ===== hdl/cpu8_alu_with_flags.sv =====
// ----------------------------------------------------------------------------
// cpu8_alu_with_flags
// An accepted item moves through the input, execute and flag/output stages.
// Throughput is one item per cycle while out_stall is low.
// Each stage advances when the stage after it is empty or moving on.
// Synchronous active-low reset empties all stages; payload is not reset.
// ----------------------------------------------------------------------------
module cpu8_alu_with_flags
  import c8alu_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [OpWidth-1:0]   in_req_type,
  input  logic [DataWidth-1:0] in_first_operand,
  input  logic [DataWidth-1:0] in_second_operand,
  input  logic                 in_carry_in,
  input  logic                 in_sign_in,
  input  logic                 in_zero_in,
  input  logic                 in_parity_in,
  input  logic                 in_aux_in,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [DataWidth-1:0] out_result,
  output logic                 out_writes_result,
  output logic                 out_sign_out,
  output logic                 out_zero_out,
  output logic                 out_parity_out,
  output logic                 out_carry_out,
  output logic                 out_aux_out
);

  alu_req_t             req_r;
  alu_exe_t             exe_r;
  alu_exe_t             exe_nxt;
  logic                 v1_r;
  logic                 v2_r;
  logic                 v3_r;
  logic                 adv1;
  logic                 adv2;
  logic                 adv3;
  logic [DataWidth-1:0] res_r;
  logic                 wr_r;
  logic                 s_r;
  logic                 z_r;
  logic                 p_r;
  logic                 cy_r;
  logic                 ac_r;

  assign adv3     = !v3_r || !out_stall;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  c8alu_exec u_exec (
    .req (req_r),
    .exe (exe_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (adv1) begin
        v1_r <= in_valid;
      end
      if (adv2) begin
        v2_r <= v1_r;
      end
      if (adv3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      req_r.op <= in_req_type;
      req_r.a  <= in_first_operand;
      req_r.b  <= in_second_operand;
      req_r.cy <= in_carry_in;
      req_r.s  <= in_sign_in;
      req_r.z  <= in_zero_in;
      req_r.p  <= in_parity_in;
      req_r.ac <= in_aux_in;
    end
    if (adv2) begin
      exe_r <= exe_nxt;
    end
    if (adv3) begin
      res_r <= exe_r.res;
      wr_r  <= exe_r.wr;
      cy_r  <= exe_r.cy;
      ac_r  <= exe_r.ac;
      s_r   <= exe_r.szp ? exe_r.res[DataWidth-1] : exe_r.s;
      z_r   <= exe_r.szp ? (exe_r.res == '0) : exe_r.z;
      p_r   <= exe_r.szp ? ~(^exe_r.res) : exe_r.p;
    end
  end

  assign out_valid         = v3_r;
  assign out_result        = res_r;
  assign out_writes_result = wr_r;
  assign out_sign_out      = s_r;
  assign out_zero_out      = z_r;
  assign out_parity_out    = p_r;
  assign out_carry_out     = cy_r;
  assign out_aux_out       = ac_r;

`ifndef SYNTHESIS
  // An empty output stage means the whole pipeline can move.
  a_empty_out_accepts: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output stage is empty");

  // A full pipeline behind a stalled output must hold off new items.
  a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && out_stall) |-> in_stall)
    else $error("item accepted into a full stalled pipeline");

  // Reset leaves no item in the output stage.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  // An item in the execute stage reaches the output when it advances.
  a_exec_moves: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && adv3) |=> out_valid)
    else $error("item lost between execute and output stages");
`endif

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives operations into the 8-bit ALU; the jittered tests add random gaps on
// the input side and random stalls on the result side. Every accepted item is
// run through a local model of the ALU, and each result is checked field by
// field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import c8alu_pkg::*;

  localparam logic [OpWidth-1:0] OP_SPARE_LO = 5'd17;
  localparam logic [OpWidth-1:0] OP_SPARE_HI = 5'd31;
  localparam int unsigned        IdleLimit   = 2000;

  typedef struct packed {
    logic [DataWidth-1:0] res;
    logic                 wr;
    logic                 s;
    logic                 z;
    logic                 p;
    logic                 cy;
    logic                 ac;
  } alu_outcome_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [OpWidth-1:0]   in_req_type;
  logic [DataWidth-1:0] in_first_operand;
  logic [DataWidth-1:0] in_second_operand;
  logic                 in_carry_in;
  logic                 in_sign_in;
  logic                 in_zero_in;
  logic                 in_parity_in;
  logic                 in_aux_in;
  logic                 out_valid;
  logic                 out_stall;
  logic [DataWidth-1:0] out_result;
  logic                 out_writes_result;
  logic                 out_sign_out;
  logic                 out_zero_out;
  logic                 out_parity_out;
  logic                 out_carry_out;
  logic                 out_aux_out;

  alu_outcome_t pending_outcomes[$];
  int unsigned  errors;
  int unsigned  quiet_cycles = 0;
  int unsigned  stall_left;
  bit           jitter_on;

  cpu8_alu_with_flags DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_first_operand  (in_first_operand),
    .in_second_operand (in_second_operand),
    .in_carry_in       (in_carry_in),
    .in_sign_in        (in_sign_in),
    .in_zero_in        (in_zero_in),
    .in_parity_in      (in_parity_in),
    .in_aux_in         (in_aux_in),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result        (out_result),
    .out_writes_result (out_writes_result),
    .out_sign_out      (out_sign_out),
    .out_zero_out      (out_zero_out),
    .out_parity_out    (out_parity_out),
    .out_carry_out     (out_carry_out),
    .out_aux_out       (out_aux_out)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic alu_outcome_t alu_predict(alu_req_t req);
    alu_outcome_t o;
    logic [8:0]   sum;
    logic [4:0]   nib;
    logic [7:0]   nb;
    logic         cin;
    logic         szp;
    o     = '{res: req.a, wr: 1'b0, s: req.s, z: req.z, p: req.p, cy: req.cy, ac: req.ac};
    szp   = 1'b0;
    case (alu_op_t'(req.op))
      OP_ADD, OP_ADC: begin
        cin   = (req.op == OP_ADC) ? req.cy : 1'b0;
        sum   = {1'b0, req.a} + {1'b0, req.b} + {8'd0, cin};
        nib   = {1'b0, req.a[3:0]} + {1'b0, req.b[3:0]} + {4'd0, cin};
        o.res = sum[7:0];
        o.cy  = sum[8];
        o.ac  = nib[4];
        o.wr  = 1'b1;
        szp   = 1'b1;
      end
      OP_SUB, OP_SBB, OP_CMP: begin
        cin   = (req.op == OP_SBB) ? ~req.cy : 1'b1;
        nb    = ~req.b;
        sum   = {1'b0, req.a} + {1'b0, nb} + {8'd0, cin};
        nib   = {1'b0, req.a[3:0]} + {1'b0, nb[3:0]} + {4'd0, cin};
        o.res = sum[7:0];
        o.cy  = ~sum[8];
        o.ac  = nib[4];
        o.wr  = (req.op != OP_CMP);
        szp   = 1'b1;
      end
      OP_ANA: begin
        o.res = req.a & req.b;
        o.cy  = 1'b0;
        o.ac  = req.a[3] | req.b[3];
        o.wr  = 1'b1;
        szp   = 1'b1;
      end
      OP_XRA: begin
        o.res = req.a ^ req.b;
        o.cy  = 1'b0;
        o.ac  = 1'b0;
        o.wr  = 1'b1;
        szp   = 1'b1;
      end
      OP_ORA: begin
        o.res = req.a | req.b;
        o.cy  = 1'b0;
        o.ac  = 1'b0;
        o.wr  = 1'b1;
        szp   = 1'b1;
      end
      OP_INR: begin
        o.res = req.a + 8'd1;
        o.ac  = (req.a[3:0] == 4'hF);
        o.wr  = 1'b1;
        szp   = 1'b1;
      end
      OP_DCR: begin
        o.res = req.a - 8'd1;
        o.ac  = (req.a[3:0] != 4'h0);
        o.wr  = 1'b1;
        szp   = 1'b1;
      end
      OP_RLC: begin
        o.res = {req.a[6:0], req.a[7]};
        o.cy  = req.a[7];
        o.wr  = 1'b1;
      end
      OP_RRC: begin
        o.res = {req.a[0], req.a[7:1]};
        o.cy  = req.a[0];
        o.wr  = 1'b1;
      end
      OP_RAL: begin
        o.res = {req.a[6:0], req.cy};
        o.cy  = req.a[7];
        o.wr  = 1'b1;
      end
      OP_RAR: begin
        o.res = {req.cy, req.a[7:1]};
        o.cy  = req.a[0];
        o.wr  = 1'b1;
      end
      OP_CMA: begin
        o.res = ~req.a;
        o.wr  = 1'b1;
      end
      OP_STC: begin
        o.cy = 1'b1;
      end
      OP_CMC: begin
        o.cy = ~req.cy;
      end
      default: begin
      end
    endcase
    if (szp) begin
      o.s = o.res[7];
      o.z = (o.res == 8'h00);
      o.p = ~^o.res;
    end
    return o;
  endfunction

  function automatic int unsigned pick_len();
    return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic [DataWidth-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h0F;
      3:       return 8'h80;
      4:       return 8'h7F;
      default: return DataWidth'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [OpWidth-1:0] pick_op();
    if ($urandom_range(0, 11) == 0) begin
      return OpWidth'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    end
    return OpWidth'($urandom_range(OP_ADD, OP_CMC));
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_item(input alu_req_t req);
    int unsigned gap;
    gap = (jitter_on && $urandom_range(0, 3) == 0) ? pick_len() : 0;
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid          = 1'b1;
    in_req_type       = req.op;
    in_first_operand  = req.a;
    in_second_operand = req.b;
    in_carry_in       = req.cy;
    in_sign_in        = req.s;
    in_zero_in        = req.z;
    in_parity_in      = req.p;
    in_aux_in         = req.ac;
    do @(posedge clk); while (in_stall);
    pending_outcomes.push_back(alu_predict(req));
    @(negedge clk);
  endtask

  task automatic send_op(input logic [OpWidth-1:0] op, input logic [7:0] a,
                         input logic [7:0] b, input logic [4:0] flags);
    send_item('{op: op, a: a, b: b, cy: flags[4], s: flags[3], z: flags[2],
                p: flags[1], ac: flags[0]});
  endtask

  task automatic send_random_op();
    send_op(pick_op(), pick_byte(), pick_byte(), 5'($urandom_range(0, 31)));
  endtask

  task automatic wait_for_drain();
    in_valid = 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic test_directed_cases();
    jitter_on = 1'b0;
    send_op(OP_ADD, 8'hFF, 8'h01, 5'b00000);
    send_op(OP_ADC, 8'h7F, 8'h00, 5'b10000);
    send_op(OP_ADC, 8'hFF, 8'hFF, 5'b11111);
    send_op(OP_SUB, 8'h00, 8'h01, 5'b00000);
    send_op(OP_SUB, 8'h80, 8'h80, 5'b11111);
    send_op(OP_SBB, 8'h00, 8'h00, 5'b10000);
    send_op(OP_SBB, 8'hFF, 8'hFF, 5'b00000);
    send_op(OP_ANA, 8'h08, 8'h00, 5'b10000);
    send_op(OP_ANA, 8'hFF, 8'hFF, 5'b00000);
    send_op(OP_XRA, 8'hAA, 8'hAA, 5'b11111);
    send_op(OP_ORA, 8'h00, 8'h00, 5'b11111);
    send_op(OP_CMP, 8'h10, 8'h10, 5'b00000);
    send_op(OP_INR, 8'hFF, 8'h00, 5'b10000);
    send_op(OP_INR, 8'h0F, 8'hFF, 5'b00000);
    send_op(OP_DCR, 8'h00, 8'h00, 5'b00000);
    send_op(OP_DCR, 8'h10, 8'hFF, 5'b10000);
    send_op(OP_RLC, 8'h80, 8'h00, 5'b00000);
    send_op(OP_RRC, 8'h01, 8'h00, 5'b00000);
    send_op(OP_RAL, 8'h7F, 8'h00, 5'b10000);
    send_op(OP_RAR, 8'hFE, 8'h00, 5'b10000);
    send_op(OP_CMA, 8'h5A, 8'hA5, 5'b01010);
    send_op(OP_STC, 8'h33, 8'h00, 5'b00000);
    send_op(OP_CMC, 8'hCC, 8'h00, 5'b10101);
    send_op(OP_SPARE_LO, 8'hC3, 8'h3C, 5'b01101);
    send_op(OP_SPARE_HI, 8'h00, 8'hFF, 5'b10010);
  endtask

  task automatic test_random_with_gaps();
    jitter_on = 1'b1;
    repeat (1200) send_random_op();
  endtask

  // The sender holds off until every result of a burst has been delivered.
  task automatic test_bursts_with_drain();
    jitter_on = 1'b1;
    repeat (10) begin
      repeat ($urandom_range(10, 30)) send_random_op();
      wait_for_drain();
    end
  endtask

  task automatic test_back_to_back();
    jitter_on = 1'b0;
    repeat (400) send_random_op();
  endtask

  task automatic check_field(input string field, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin : check_results
    alu_outcome_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        errors++;
        $display("%0t: result expected none, got %0h", $time, out_result);
      end else begin
        want = pending_outcomes.pop_front();
        check_field("result", want.res, out_result);
        check_field("writes_result", 8'(want.wr), 8'(out_writes_result));
        check_field("sign", 8'(want.s), 8'(out_sign_out));
        check_field("zero", 8'(want.z), 8'(out_zero_out));
        check_field("parity", 8'(want.p), 8'(out_parity_out));
        check_field("carry", 8'(want.cy), 8'(out_carry_out));
        check_field("aux", 8'(want.ac), 8'(out_aux_out));
      end
    end
  end

  initial begin
    out_stall  = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left != 0) begin
        out_stall = 1'b1;
        stall_left--;
      end else begin
        out_stall = 1'b0;
        if (jitter_on && $urandom_range(0, 4) == 0) begin
          stall_left = pick_len();
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    errors            = 0;
    jitter_on         = 1'b0;
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_req_type       = '0;
    in_first_operand  = '0;
    in_second_operand = '0;
    in_carry_in       = 1'b0;
    in_sign_in        = 1'b0;
    in_zero_in        = 1'b0;
    in_parity_in      = 1'b0;
    in_aux_in         = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed_cases();
    test_random_with_gaps();
    test_bursts_with_drain();
    test_back_to_back();
    wait_for_drain();
    if (pending_outcomes.size() != 0) begin
      errors++;
    end
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
